### hdl/pdct_pkg.sv
// Shared types, codes and constants of the pointer delta cursor tracker.
package pdct_pkg;

  localparam int ACC_BITS_DEF = 24;
  localparam int CFG_IDX_W    = 1;
  localparam int SIZE_W       = 15;
  localparam int DELTA_W      = 16;
  localparam int BTN_W        = 8;
  localparam int Q8_W         = 26;

  localparam logic [SIZE_W-1:0] SIZE_MAX_PX       = 15'd16384;
  localparam logic [SIZE_W-1:0] RST_SCREEN_WIDTH  = 15'd1920;
  localparam logic [SIZE_W-1:0] RST_SCREEN_HEIGHT = 15'd1080;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_CONSUME = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OWN_NONE = 2'd0,
    OWN_SRC0 = 2'd1,
    OWN_SRC1 = 2'd2
  } owner_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic                       src_id;
    logic signed [DELTA_W-1:0]  delta_x;
    logic signed [DELTA_W-1:0]  delta_y;
    logic signed [DELTA_W-1:0]  wheel_delta;
    logic [BTN_W-1:0]           button_mask;
  } item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] x_half;
    logic [SIZE_W-1:0] y_half;
    logic              left_held;
    logic              left_pressed;
    logic              left_released;
  } cursor_t;

  // floor(32 * r / 15) for a remainder r of a division by 15
  function automatic logic [4:0] wheel_frac(input logic [3:0] r);
    logic [4:0] f;
    unique case (r)
      4'd0:    f = 5'd0;
      4'd1:    f = 5'd2;
      4'd2:    f = 5'd4;
      4'd3:    f = 5'd6;
      4'd4:    f = 5'd8;
      4'd5:    f = 5'd10;
      4'd6:    f = 5'd12;
      4'd7:    f = 5'd14;
      4'd8:    f = 5'd17;
      4'd9:    f = 5'd19;
      4'd10:   f = 5'd21;
      4'd11:   f = 5'd23;
      4'd12:   f = 5'd25;
      4'd13:   f = 5'd27;
      4'd14:   f = 5'd29;
      default: f = 5'd0;
    endcase
    return f;
  endfunction

endpackage

### hdl/pointer_delta_cursor_tracker.sv
// Top level of the pointer delta cursor tracker: ports, configuration, input register.
//
// Input words arrive on s_tvalid/s_tready; tuser carries the command (push,
// consume, clear) and the source id, tdata the motion, wheel and buttons.
// Pushes from the owning source add into saturating accumulators; a consume
// moves the half-pixel cursor, clamps it to the screen and emits one word on
// m_tvalid/m_tready. Push, clear and unused codes emit nothing.
// Screen size registers are written on cfg_valid/cfg_ready (always ready);
// write them only while no word is in flight.
// Throughput: one input word per cycle while consumes are not held back. Each word
// is handled out of the input register; a consume's result then passes the
// wheel multiply and the wheel remainder stage before it shows on m_tvalid.
// A stalled receiver holds the output register; pushes and clears keep
// flowing until a consume finds the three result stages full, then that
// consume waits in the input register and holds s_tready low.
// Reset clears ownership, accumulators, cursor and all valid flags, and sets
// the screen to 1920 x 1080.
module pointer_delta_cursor_tracker #(
  parameter int ACC_BITS = pdct_pkg::ACC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // delta_x[15:0], delta_y[31:16], wheel_delta[47:32], button_mask[55:48]
  input  logic [55:0]                       s_tdata,
  // cmd[1:0], src_id[2]
  input  logic [2:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // cursor_x_half[14:0], cursor_y_half[29:15], left_held[30], left_pressed[31],
  // left_released[32], wheel_steps_q8[58:33], zero[63:59]
  output logic [63:0]                       m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pdct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdct_pkg::SIZE_W-1:0]       cfg_data
);

  logic [pdct_pkg::SIZE_W-1:0]       screen_width, screen_height;
  logic                              item_valid;
  pdct_pkg::item_t                   item;
  logic                              item_done;
  logic                              snap_valid;
  pdct_pkg::cursor_t                 snap;
  logic signed [ACC_BITS-1:0]        snap_wheel;
  logic                              div_ready;
  pdct_pkg::cursor_t                 out_info;
  logic signed [pdct_pkg::Q8_W-1:0]  out_q8;

  assign cfg_ready = 1'b1;
  assign s_tready  = !item_valid || item_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= pdct_pkg::RST_SCREEN_WIDTH;
      screen_height <= pdct_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pdct_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        pdct_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      item.cmd         <= pdct_pkg::cmd_t'(s_tuser[1:0]);
      item.src_id      <= s_tuser[2];
      item.delta_x     <= s_tdata[15:0];
      item.delta_y     <= s_tdata[31:16];
      item.wheel_delta <= s_tdata[47:32];
      item.button_mask <= s_tdata[55:48];
    end
  end

  pdct_tracker #(
    .ACC_BITS (ACC_BITS)
  ) u_tracker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .div_ready     (div_ready),
    .item_done     (item_done),
    .snap_valid    (snap_valid),
    .snap          (snap),
    .snap_wheel    (snap_wheel)
  );

  pdct_wheel_div #(
    .ACC_BITS (ACC_BITS)
  ) u_wheel_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (snap_valid),
    .in_ready  (div_ready),
    .in_info   (snap),
    .in_wheel  (snap_wheel),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_info  (out_info),
    .out_q8    (out_q8)
  );

  assign m_tdata = {5'b0, out_q8, out_info.left_released, out_info.left_pressed,
                    out_info.left_held, out_info.y_half, out_info.x_half};

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> s_tready)
    else $error("input register empty but not ready");

  a_push_never_stalls: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item.cmd == pdct_pkg::CMD_PUSH) |-> item_done)
    else $error("push held behind the result path");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[14:0] != 15'h7FFF && m_tdata[29:15] != 15'h7FFF))
    else $error("cursor beyond clamp range");

  a_edges_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[31] && m_tdata[32]))
    else $error("press and release in one word");
`endif

endmodule

### hdl/pdct_tracker.sv
// Ownership, saturating accumulators and cursor move for one word per cycle while div_ready takes consumes.
module pdct_tracker #(
  parameter int ACC_BITS = pdct_pkg::ACC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  input  pdct_pkg::item_t                       item,
  input  logic [pdct_pkg::SIZE_W-1:0]           screen_width,
  input  logic [pdct_pkg::SIZE_W-1:0]           screen_height,
  input  logic                                  div_ready,
  output logic                                  item_done,
  output logic                                  snap_valid,
  output pdct_pkg::cursor_t                     snap,
  output logic signed [ACC_BITS-1:0]            snap_wheel
);

  localparam logic [ACC_BITS-1:0] ACC_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic [ACC_BITS-1:0] ACC_LO = {1'b1, {(ACC_BITS-1){1'b0}}};

  pdct_pkg::owner_t                  owner, owner_next;
  logic [pdct_pkg::BTN_W-1:0]        latched_buttons, latched_buttons_next;
  logic signed [ACC_BITS-1:0]        acc_dx, acc_dx_next;
  logic signed [ACC_BITS-1:0]        acc_dy, acc_dy_next;
  logic signed [ACC_BITS-1:0]        acc_wheel, acc_wheel_next;
  logic                              seeded, seeded_next;
  logic                              prev_left, prev_left_next;
  logic [pdct_pkg::SIZE_W-1:0]       pos_x_half, pos_x_half_next;
  logic [pdct_pkg::SIZE_W-1:0]       pos_y_half, pos_y_half_next;

  logic [pdct_pkg::SIZE_W-1:0]       w_eff, h_eff, w_m1, h_m1, lim_x, lim_y;
  logic [pdct_pkg::SIZE_W-1:0]       new_x, new_y;
  logic                              left;
  logic                              carries, take;
  pdct_pkg::owner_t                  src_code;

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0]         a,
    input logic signed [pdct_pkg::DELTA_W-1:0] d
  );
    logic signed [ACC_BITS:0] s;
    s = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(d);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      return s[ACC_BITS] ? ACC_LO : ACC_HI;
    end
    return s[ACC_BITS-1:0];
  endfunction

  function automatic logic [pdct_pkg::SIZE_W-1:0] move_axis(
    input logic [pdct_pkg::SIZE_W-1:0] base,
    input logic signed [ACC_BITS-1:0]  acc,
    input logic [pdct_pkg::SIZE_W-1:0] limit
  );
    logic signed [ACC_BITS+1:0] b_s, a_s, l_s, v;
    b_s = $signed((ACC_BITS+2)'(base));
    a_s = $signed({acc[ACC_BITS-1], acc, 1'b0});
    l_s = $signed((ACC_BITS+2)'(limit));
    v   = b_s + a_s;
    if (v < 0) begin
      return '0;
    end
    if (v > l_s) begin
      return limit;
    end
    return v[pdct_pkg::SIZE_W-1:0];
  endfunction

  // A zero size acts as one pixel, anything past the maximum as the maximum.
  always_comb begin
    if (screen_width == '0) begin
      w_eff = pdct_pkg::SIZE_W'(1);
    end else if (screen_width > pdct_pkg::SIZE_MAX_PX) begin
      w_eff = pdct_pkg::SIZE_MAX_PX;
    end else begin
      w_eff = screen_width;
    end
    if (screen_height == '0) begin
      h_eff = pdct_pkg::SIZE_W'(1);
    end else if (screen_height > pdct_pkg::SIZE_MAX_PX) begin
      h_eff = pdct_pkg::SIZE_MAX_PX;
    end else begin
      h_eff = screen_height;
    end
    w_m1  = w_eff - pdct_pkg::SIZE_W'(1);
    h_m1  = h_eff - pdct_pkg::SIZE_W'(1);
    lim_x = {w_m1[pdct_pkg::SIZE_W-2:0], 1'b0};
    lim_y = {h_m1[pdct_pkg::SIZE_W-2:0], 1'b0};
  end

  // Unseeded cursor starts at the center and drops motion gathered so far.
  always_comb begin
    new_x = move_axis(seeded ? pos_x_half : w_eff, seeded ? acc_dx : '0, lim_x);
    new_y = move_axis(seeded ? pos_y_half : h_eff, seeded ? acc_dy : '0, lim_y);
    left  = latched_buttons[0];
    snap.x_half        = new_x;
    snap.y_half        = new_y;
    snap.left_held     = left;
    snap.left_pressed  = left && !prev_left;
    snap.left_released = !left && prev_left;
    snap_wheel         = acc_wheel;
  end

  always_comb begin
    carries  = (item.delta_x != '0) || (item.delta_y != '0) ||
               (item.wheel_delta != '0) || (item.button_mask != '0);
    src_code = item.src_id ? pdct_pkg::OWN_SRC1 : pdct_pkg::OWN_SRC0;
    take     = (owner == pdct_pkg::OWN_NONE) ? carries : (owner == src_code);
  end

  always_comb begin
    owner_next           = owner;
    latched_buttons_next = latched_buttons;
    acc_dx_next          = acc_dx;
    acc_dy_next          = acc_dy;
    acc_wheel_next       = acc_wheel;
    seeded_next          = seeded;
    prev_left_next       = prev_left;
    pos_x_half_next      = pos_x_half;
    pos_y_half_next      = pos_y_half;
    item_done  = item_valid && ((item.cmd != pdct_pkg::CMD_CONSUME) || div_ready);
    snap_valid = 1'b0;
    if (item_done) begin
      unique case (item.cmd)
        pdct_pkg::CMD_PUSH: begin
          if (owner == pdct_pkg::OWN_NONE && carries) begin
            owner_next = src_code;
          end
          if (take) begin
            latched_buttons_next = item.button_mask;
            acc_dx_next          = sat_add(acc_dx, item.delta_x);
            acc_dy_next          = sat_add(acc_dy, item.delta_y);
            acc_wheel_next       = sat_add(acc_wheel, item.wheel_delta);
          end
        end
        pdct_pkg::CMD_CONSUME: begin
          snap_valid      = 1'b1;
          seeded_next     = 1'b1;
          pos_x_half_next = new_x;
          pos_y_half_next = new_y;
          acc_dx_next     = '0;
          acc_dy_next     = '0;
          acc_wheel_next  = '0;
          prev_left_next  = left;
        end
        pdct_pkg::CMD_CLEAR: begin
          owner_next           = pdct_pkg::OWN_NONE;
          latched_buttons_next = '0;
          acc_dx_next          = '0;
          acc_dy_next          = '0;
          acc_wheel_next       = '0;
          seeded_next          = 1'b0;
          prev_left_next       = 1'b0;
          pos_x_half_next      = '0;
          pos_y_half_next      = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner           <= pdct_pkg::OWN_NONE;
      latched_buttons <= '0;
      acc_dx          <= '0;
      acc_dy          <= '0;
      acc_wheel       <= '0;
      seeded          <= 1'b0;
      prev_left       <= 1'b0;
      pos_x_half      <= '0;
      pos_y_half      <= '0;
    end else begin
      owner           <= owner_next;
      latched_buttons <= latched_buttons_next;
      acc_dx          <= acc_dx_next;
      acc_dy          <= acc_dy_next;
      acc_wheel       <= acc_wheel_next;
      seeded          <= seeded_next;
      prev_left       <= prev_left_next;
      pos_x_half      <= pos_x_half_next;
      pos_y_half      <= pos_y_half_next;
    end
  end

endmodule

### hdl/pdct_wheel_div.sv
// Wheel scaling by 256/120 in three stages, carrying the cursor word to the output register.
module pdct_wheel_div #(
  parameter int ACC_BITS = pdct_pkg::ACC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  pdct_pkg::cursor_t                     in_info,
  input  logic signed [ACC_BITS-1:0]            in_wheel,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pdct_pkg::cursor_t                     out_info,
  output logic signed [pdct_pkg::Q8_W-1:0]      out_q8
);

  // floor(m / 15) = (m * RECIP) >> SHIFT, exact for every ACC_BITS-bit m
  localparam int               SHIFT   = ACC_BITS + 4;
  localparam longint unsigned  RECIP_L = ((64'd1 << SHIFT) + 64'd14) / 64'd15;
  localparam logic [ACC_BITS:0] RECIP  = (ACC_BITS+1)'(RECIP_L);
  localparam int               PROD_W  = 2 * ACC_BITS + 1;
  localparam int               QD_W    = PROD_W - SHIFT;
  localparam int               WQ      = (ACC_BITS + 3 > pdct_pkg::Q8_W) ?
                                         ACC_BITS + 3 : pdct_pkg::Q8_W;

  logic                    a_valid, b_valid;
  pdct_pkg::cursor_t       a_info, b_info;
  logic [ACC_BITS-1:0]     a_mag, b_mag;
  logic                    a_neg, b_neg;
  logic [PROD_W-1:0]       b_prod;
  logic                    free_a, free_b, free_o;

  logic [ACC_BITS-1:0]     in_mag;
  logic [QD_W-1:0]         qd;
  logic [ACC_BITS-1:0]     rem_full;
  logic [ACC_BITS+1:0]     q_mag;
  logic signed [WQ-1:0]    q_s;

  assign free_o   = !out_valid || out_ready;
  assign free_b   = !b_valid || free_o;
  assign free_a   = !a_valid || free_b;
  assign in_ready = free_a;

  always_comb begin
    in_mag   = in_wheel[ACC_BITS-1] ? ACC_BITS'(-in_wheel) : in_wheel;
    qd       = b_prod[PROD_W-1:SHIFT];
    rem_full = b_mag - ACC_BITS'({qd, 4'b0}) + ACC_BITS'(qd);
    q_mag    = (ACC_BITS+2)'({qd, 5'b0}) + (ACC_BITS+2)'(pdct_pkg::wheel_frac(rem_full[3:0]));
    q_s      = $signed(WQ'(q_mag));
    if (b_neg) begin
      q_s = -q_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (free_a) begin
        a_valid <= in_valid;
      end
      if (free_b) begin
        b_valid <= a_valid;
      end
      if (free_o) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free_a) begin
      a_info <= in_info;
      a_mag  <= in_mag;
      a_neg  <= in_wheel[ACC_BITS-1];
    end
    if (free_b) begin
      b_info <= a_info;
      b_mag  <= a_mag;
      b_neg  <= a_neg;
      b_prod <= PROD_W'(a_mag) * PROD_W'(RECIP);
    end
    if (free_o) begin
      out_info <= b_info;
      out_q8   <= q_s[pdct_pkg::Q8_W-1:0];
    end
  end

endmodule
